/* hw/rtl/call_stack_exclusive_time_profiler_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the call stack exclusive time profiler.
// Defining NO_ASSERTIONS turns every check into an empty statement.
// ---------------------------------------------------------------------------
`ifndef CALL_STACK_EXCLUSIVE_TIME_PROFILER_TOP_DEFINES_SVH
`define CALL_STACK_EXCLUSIVE_TIME_PROFILER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define CSTP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSTP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define CSTP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg)
`define CSTP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

/* hw/rtl/cstp_pkg.sv */
// ---------------------------------------------------------------------------
// cstp_pkg
// Shared constants and types of the call stack exclusive time profiler.
// ---------------------------------------------------------------------------
`default_nettype none

package cstp_pkg;

	// Default sizes of the totals table and the call stack.
	localparam int NUM_FUNCS_DEF   = 256;
	localparam int STACK_DEPTH_DEF = 64;

	// Fixed field widths.
	localparam int ID_W   = 8;
	localparam int TIME_W = 32;
	localparam int ST_W   = 2;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_CHARGED   = 2'd0;
	localparam logic [ST_W-1:0] ST_NONE      = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd3;

	// Requests from the sequencer to the stack unit.
	typedef struct packed {
		logic            peek;
		logic            push;
		logic            pop;
		logic [ID_W-1:0] id;
	} stk_cmd_t;

	// Condition of the stack as seen by the sequencer.
	typedef struct packed {
		logic            empty;
		logic            full;
		logic [ID_W-1:0] top;
	} stk_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/cstp_if.sv */
// ---------------------------------------------------------------------------
// cstp_if
// Valid/ready channels: trace events in, charge results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface cstp_in_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [cstp_pkg::ID_W-1:0]   func_id;
	logic [cstp_pkg::TIME_W-1:0] stamp;

	modport source (output valid, cmd, func_id, stamp, input ready);
	modport sink   (input valid, cmd, func_id, stamp, output ready);
endinterface

interface cstp_out_if;
	logic                        valid;
	logic                        ready;
	logic [cstp_pkg::ID_W-1:0]   charged_id;
	logic [cstp_pkg::TIME_W-1:0] charged_total;
	logic [cstp_pkg::ST_W-1:0]   status;

	modport source (output valid, charged_id, charged_total, status, input ready);
	modport sink   (input valid, charged_id, charged_total, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cstp_ram.sv */
// ---------------------------------------------------------------------------
// cstp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cstp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cstp_stack.sv */
// ---------------------------------------------------------------------------
// cstp_stack
// Call stack: level and top in registers, the entries in a RAM. A peek reads
// the entry under the top so that a pop in the next cycle can restore it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "call_stack_exclusive_time_profiler_top_defines.svh"

module cstp_stack #(
	parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cstp_pkg::stk_cmd_t  cmd,
	output cstp_pkg::stk_stat_t      stat
);

	localparam int LvW = $clog2(STACK_DEPTH + 1);
	localparam int SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int IdW = cstp_pkg::ID_W;

	logic [LvW-1:0] level_q;
	logic [IdW-1:0] top_q;
	logic [IdW-1:0] below_rdata;
	logic [LvW-1:0] below_level;

	// Level and top register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cmd.push) begin
			level_q <= level_q + LvW'(1);
		end else if (cmd.pop) begin
			level_q <= level_q - LvW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.push) begin
			top_q <= cmd.id;
		end else if (cmd.pop) begin
			top_q <= below_rdata;
		end
	end

	assign below_level = level_q - LvW'(2);

	// Entry storage; a push writes at the current level.
	cstp_ram #(
		.WIDTH(IdW),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(level_q[SaW-1:0]),
		.wdata(cmd.id),
		.re   (cmd.peek),
		.raddr(below_level[SaW-1:0]),
		.rdata(below_rdata)
	);

	assign stat.empty = (level_q == '0);
	assign stat.full  = (level_q == LvW'(STACK_DEPTH));
	assign stat.top   = top_q;

	`CSTP_ASSERT_NOW(a_push_not_full, clk, arst_n, cmd.push, level_q != LvW'(STACK_DEPTH), "push on a full stack")
	`CSTP_ASSERT_NOW(a_pop_not_empty, clk, arst_n, cmd.pop, level_q != '0, "pop on an empty stack")
	`CSTP_ASSERT_NOW(a_push_pop_excl, clk, arst_n, cmd.push, !cmd.pop, "push and pop together")
	`CSTP_ASSERT_NEXT(a_push_level, clk, arst_n, cmd.push, level_q == $past(level_q) + LvW'(1), "level did not rise on push")

endmodule

`default_nettype wire

/* hw/rtl/call_stack_exclusive_time_profiler_top.sv */
// ---------------------------------------------------------------------------
// call_stack_exclusive_time_profiler_top
// Exclusive time per function from a stream of start and end trace events.
//
// Usage:
// - events: one word per trace event (cmd 0 start, 1 end, func_id, stamp).
//   func_id is reduced modulo NUM_FUNCS before use.
// - results: one word per event (charged_id, charged_total, status).
// - Latency: a result is valid from the clock edge after the one that takes
//   its event, when the result register is free.
// - Throughput: one event every two cycles: the accept cycle reads the
//   totals RAM and the stack RAM, the next cycle adds, saturates and
//   writes both back. The next event is taken only after that write.
// - Reset: after arst_n is released the totals RAM is swept to zero, one
//   entry per cycle, for NUM_FUNCS cycles; events.ready stays low meanwhile.
//   Stack level and last mark restart at zero.
// - Stall: the result register holds its word until results.ready. A new
//   event may be taken meanwhile; its result waits in a holding register
//   and events.ready stays low until the result register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

`include "call_stack_exclusive_time_profiler_top_defines.svh"

module call_stack_exclusive_time_profiler_top #(
	parameter int NUM_FUNCS   = cstp_pkg::NUM_FUNCS_DEF,
	parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cstp_in_if.sink   events,
	cstp_out_if.source results
);

	localparam int TblAw = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
	localparam int IdW   = cstp_pkg::ID_W;
	localparam int TimeW = cstp_pkg::TIME_W;
	localparam int StW   = cstp_pkg::ST_W;
	localparam int IdNum = 1 << IdW;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CALC  = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		OP_OVF,
		OP_UNF,
		OP_FIRST,
		OP_PUSH,
		OP_POP
	} op_t;

	state_t              state_q, state_d;
	logic [TblAw-1:0]    clr_q;
	logic [TimeW-1:0]    mark_q;
	logic                accept;
	logic                out_free;

	logic [IdW-1:0]      fid_mod [IdNum];
	logic [TimeW:0]      diff;
	logic [TimeW-1:0]    elapsed;
	logic [TimeW-1:0]    mark_nx;
	op_t                 op_d;

	op_t                 op_s1;
	logic [IdW-1:0]      fid_s1;
	logic [TimeW-1:0]    elapsed_s1;
	logic                is_end_s1;
	logic [TimeW-1:0]    mark_s1;

	cstp_pkg::stk_cmd_t  stk_cmd;
	cstp_pkg::stk_stat_t stk_stat;
	logic [TblAw-1:0]    top_addr;

	logic [TimeW-1:0]    tot_rdata;
	logic                tot_we;
	logic [TblAw-1:0]    tot_waddr;
	logic [TimeW-1:0]    tot_wdata;
	logic [TimeW:0]      sum;
	logic [TimeW-1:0]    sat_total;
	logic                charge;

	logic [IdW-1:0]      res_id;
	logic [TimeW-1:0]    res_total;
	logic [StW-1:0]      res_status;
	logic [IdW-1:0]      pend_id_q;
	logic [TimeW-1:0]    pend_total_q;
	logic [StW-1:0]      pend_status_q;

	logic                out_valid_q;
	logic                out_load;
	logic [IdW-1:0]      out_id_q;
	logic [TimeW-1:0]    out_total_q;
	logic [StW-1:0]      out_status_q;

	assign accept   = events.valid && events.ready;
	assign out_free = !out_valid_q || results.ready;

	// Id reduction table, worked out at elaboration.
	for (genvar g = 0; g < IdNum; g++) begin : g_fid_mod
		assign fid_mod[g] = IdW'(g % NUM_FUNCS);
	end

	// Ticks since the mark, clamped at zero, and the next mark.
	always_comb begin
		diff    = {1'b0, events.stamp} - {1'b0, mark_q};
		elapsed = diff[TimeW] ? '0 : diff[TimeW-1:0];
		if (!events.cmd) begin
			mark_nx = events.stamp;
		end else if (events.stamp == '1) begin
			mark_nx = '1;
		end else begin
			mark_nx = events.stamp + TimeW'(1);
		end
	end

	// Classify the event against the stack condition.
	always_comb begin
		priority if (!events.cmd && stk_stat.full) begin
			op_d = OP_OVF;
		end else if (!events.cmd && stk_stat.empty) begin
			op_d = OP_FIRST;
		end else if (!events.cmd) begin
			op_d = OP_PUSH;
		end else if (stk_stat.empty) begin
			op_d = OP_UNF;
		end else begin
			op_d = OP_POP;
		end
	end

	// Event stage register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_d;
			fid_s1     <= fid_mod[events.func_id];
			elapsed_s1 <= elapsed;
			is_end_s1  <= events.cmd;
			mark_s1    <= mark_nx;
		end
	end

	// Stack requests.
	assign stk_cmd.peek = accept;
	assign stk_cmd.push = (state_q == S_CALC) && ((op_s1 == OP_FIRST) || (op_s1 == OP_PUSH));
	assign stk_cmd.pop  = (state_q == S_CALC) && (op_s1 == OP_POP);
	assign stk_cmd.id   = fid_s1;

	cstp_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (stk_cmd),
		.stat  (stk_stat)
	);

	assign top_addr = TblAw'(stk_stat.top);

	// Saturating charge; an end adds one extra tick as carry in.
	assign charge    = (op_s1 == OP_PUSH) || (op_s1 == OP_POP);
	assign sum       = {1'b0, tot_rdata} + {1'b0, elapsed_s1} + (TimeW + 1)'(is_end_s1);
	assign sat_total = sum[TimeW] ? '1 : sum[TimeW-1:0];

	// Totals RAM: clearing sweep after reset, then charge write-back.
	assign tot_we    = (state_q == S_CLEAR) || ((state_q == S_CALC) && charge);
	assign tot_waddr = (state_q == S_CLEAR) ? clr_q : top_addr;
	assign tot_wdata = (state_q == S_CLEAR) ? '0 : sat_total;

	cstp_ram #(
		.WIDTH(TimeW),
		.DEPTH(NUM_FUNCS)
	) u_totals_ram (
		.clk  (clk),
		.we   (tot_we),
		.waddr(tot_waddr),
		.wdata(tot_wdata),
		.re   (accept),
		.raddr(top_addr),
		.rdata(tot_rdata)
	);

	// Result word of the event in flight.
	always_comb begin
		res_id     = '0;
		res_total  = '0;
		res_status = cstp_pkg::ST_NONE;
		unique case (op_s1)
			OP_OVF: begin
				res_status = cstp_pkg::ST_OVERFLOW;
			end
			OP_UNF: begin
				res_status = cstp_pkg::ST_UNDERFLOW;
			end
			OP_FIRST: begin
				res_status = cstp_pkg::ST_NONE;
			end
			OP_PUSH, OP_POP: begin
				res_id     = stk_stat.top;
				res_total  = sat_total;
				res_status = cstp_pkg::ST_CHARGED;
			end
			default: begin
				res_status = cstp_pkg::ST_NONE;
			end
		endcase
	end

	// Last mark moves on every event that changes the stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (stk_cmd.push || stk_cmd.pop) begin
			mark_q <= mark_s1;
		end
	end

	// Holding register for a result that meets a busy output.
	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			pend_id_q     <= res_id;
			pend_total_q  <= res_total;
			pend_status_q <= res_status;
		end
	end

	// Output register.
	assign out_load = ((state_q == S_CALC) || (state_q == S_HOLD)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_CALC) begin
				out_id_q     <= res_id;
				out_total_q  <= res_total;
				out_status_q <= res_status;
			end else begin
				out_id_q     <= pend_id_q;
				out_total_q  <= pend_total_q;
				out_status_q <= pend_status_q;
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.charged_id    = out_id_q;
	assign results.charged_total = out_total_q;
	assign results.status        = out_status_q;
	assign events.ready          = (state_q == S_IDLE);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == TblAw'(NUM_FUNCS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				state_d = out_free ? S_IDLE : S_HOLD;
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + TblAw'(1);
		end
	end

	`CSTP_ASSERT_NEXT(a_accept_then_calc, clk, arst_n, accept, state_q == S_CALC, "accepted event not processed next cycle")
	`CSTP_ASSERT_NOW(a_drop_is_zero, clk, arst_n, results.valid && (results.status != cstp_pkg::ST_CHARGED), (results.charged_id == '0) && (results.charged_total == '0), "uncharged result carries data")
	`CSTP_ASSERT_NOW(a_no_stack_in_clear, clk, arst_n, state_q == S_CLEAR, !stk_cmd.push && !stk_cmd.pop && !accept, "stack activity during clearing sweep")
	`CSTP_ASSERT_NOW(a_charge_nonempty, clk, arst_n, (state_q == S_CALC) && charge, !stk_stat.empty, "charge with an empty stack")

endmodule

`default_nettype wire

/* test/tb_call_stack_exclusive_time_profiler_top.sv */
// ---------------------------------------------------------------------------
// tb_call_stack_exclusive_time_profiler_top
// Self-checking bench for the call stack exclusive time profiler. A short
// directed sequence covers the empty stack cases, stamps behind the mark
// and saturation of totals and mark. Random push/pop walks follow, under
// four idle mixes on the event and result channels. A ledger class predicts
// the result word of every accepted event and checks the results in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_call_stack_exclusive_time_profiler_top;

	import cstp_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 500;
	localparam int NFUNC        = NUM_FUNCS_DEF;
	localparam int DEPTH        = STACK_DEPTH_DEF;

	// Event kinds.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_END   = 1'b1;

	localparam logic [TIME_W-1:0] TICK_MAX = {TIME_W{1'b1}};

	// One expected result word.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] total;
		logic [ST_W-1:0]   status;
	} charge_t;

	// The ledger keeps its own copy of the stack, the mark and the totals,
	// and holds the result words still to come from the block.
	class exclusive_time_ledger;
		logic [ID_W-1:0]   frames [DEPTH];
		int                depth_now;
		logic [TIME_W-1:0] mark;
		logic [TIME_W-1:0] totals [NFUNC];
		charge_t           pending_charges [$];
		int                errors;
		int                checked;
		int                accepted;
		int                status_count [4];

		function new();
			depth_now = 0;
			mark = '0;
			errors = 0;
			checked = 0;
			accepted = 0;
			for (int i = 0; i < NFUNC; i++) totals[i] = '0;
			for (int i = 0; i < DEPTH; i++) frames[i] = '0;
			for (int i = 0; i < 4; i++) status_count[i] = 0;
		endfunction

		function int pending();
			return pending_charges.size();
		endfunction

		// Add an amount to one total, saturating at the top of the range.
		function logic [TIME_W-1:0] add_time(logic [ID_W-1:0] id, logic [TIME_W:0] amount);
			logic [TIME_W+1:0] sum;
			sum = {2'b00, totals[id]} + {1'b0, amount};
			if (sum > {2'b00, TICK_MAX}) sum = {2'b00, TICK_MAX};
			totals[id] = sum[TIME_W-1:0];
			return sum[TIME_W-1:0];
		endfunction

		// Work out the result of one accepted event and queue it.
		function void note_event(logic cmd, logic [ID_W-1:0] fid, logic [TIME_W-1:0] stamp);
			charge_t           r;
			logic [TIME_W-1:0] elapsed;
			logic [ID_W-1:0]   top;
			elapsed = (stamp >= mark) ? stamp - mark : '0;
			r = '{id: '0, total: '0, status: ST_NONE};
			if (cmd == CMD_START) begin
				if (depth_now >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					if (depth_now > 0) begin
						top = frames[depth_now - 1];
						r.id = top;
						r.total = add_time(top, {1'b0, elapsed});
						r.status = ST_CHARGED;
					end
					frames[depth_now] = ID_W'(int'(fid) % NFUNC);
					depth_now++;
					mark = stamp;
				end
			end else begin
				if (depth_now == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					top = frames[depth_now - 1];
					r.id = top;
					r.total = add_time(top, {1'b0, elapsed} + 1);
					r.status = ST_CHARGED;
					depth_now--;
					mark = (stamp == TICK_MAX) ? TICK_MAX : stamp + 1;
				end
			end
			status_count[r.status]++;
			accepted++;
			pending_charges.push_back(r);
		endfunction

		// Print one line per mismatch and count it.
		task flag_mismatch(string what);
			errors++;
			$display("MISMATCH %0d: %s", errors, what);
		endtask

		// Compare one accepted result word with the oldest expectation.
		task check_charge(logic [ID_W-1:0] id, logic [TIME_W-1:0] total, logic [ST_W-1:0] st);
			charge_t e;
			if (pending_charges.size() == 0) begin
				flag_mismatch($sformatf("unexpected result id=%0h total=%0h status=%0d",
					id, total, st));
			end else begin
				e = pending_charges.pop_front();
				if (id !== e.id)
					flag_mismatch($sformatf("result %0d: charged_id %0h, wanted %0h",
						checked, id, e.id));
				if (total !== e.total)
					flag_mismatch($sformatf("result %0d: charged_total %0h, wanted %0h",
						checked, total, e.total));
				if (st !== e.status)
					flag_mismatch($sformatf("result %0d: status %0d, wanted %0d",
						checked, st, e.status));
			end
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   idle_pct;
	int   stall_pct;

	logic [TIME_W-1:0] stamp_cursor;

	exclusive_time_ledger sb;

	cstp_in_if  ev_if ();
	cstp_out_if res_if ();

	call_stack_exclusive_time_profiler_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Cycle counter and run limit.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, sb.pending());
		$display("== FAIL ==");
		$finish;
	end

	// Result side: check each accepted word, then pick the next ready.
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready)
				sb.check_charge(res_if.charged_id, res_if.charged_total, res_if.status);
			res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offer one event word, after random idle cycles, and hold it until taken.
	task automatic push_event(input logic cmd, input logic [ID_W-1:0] fid,
			input logic [TIME_W-1:0] stamp);
		while ($urandom_range(0, 99) < idle_pct) begin
			ev_if.valid <= 1'b0;
			@(posedge clk);
		end
		ev_if.valid   <= 1'b1;
		ev_if.cmd     <= cmd;
		ev_if.func_id <= fid;
		ev_if.stamp   <= stamp;
		@(posedge clk);
		while (!ev_if.ready) @(posedge clk);
		sb.note_event(cmd, fid, stamp);
	endtask

	// Hand-picked events: empty and drained stack, stamps behind the mark,
	// ids at both ends of the range, and totals and mark saturating.
	task automatic run_directed();
		push_event(CMD_END,   8'h00, 32'd0);
		push_event(CMD_START, 8'h00, 32'd0);
		push_event(CMD_START, 8'hFF, 32'd5);
		push_event(CMD_START, 8'hAA, 32'd5);
		push_event(CMD_END,   8'h00, 32'd9);
		push_event(CMD_START, 8'h55, 32'd10);
		push_event(CMD_END,   8'hFF, 32'd10);
		push_event(CMD_START, 8'h01, 32'd3);
		push_event(CMD_END,   8'h00, 32'd2);
		push_event(CMD_END,   8'h00, 32'd20);
		push_event(CMD_END,   8'h00, 32'd20);
		push_event(CMD_END,   8'h00, 32'd20);
		push_event(CMD_START, 8'h10, 32'd0);
		push_event(CMD_START, 8'h20, TICK_MAX);
		push_event(CMD_END,   8'h00, TICK_MAX);
		push_event(CMD_END,   8'h00, TICK_MAX);
		push_event(CMD_START, 8'h10, TICK_MAX);
		push_event(CMD_START, 8'h30, TICK_MAX);
		push_event(CMD_END,   8'h00, TICK_MAX);
		push_event(CMD_END,   8'hFF, TICK_MAX);
		push_event(CMD_END,   8'h00, TICK_MAX);
	endtask

	// Random push/pop walks. Each stretch leans toward starts or ends; the
	// start-heavy stretches run long enough to fill the stack and overflow.
	// A few events are noise with a random stamp, often behind the mark.
	task automatic run_random_phase(input int count);
		int                sent;
		int                seg_left;
		int                start_pct;
		logic              cmd;
		logic [ID_W-1:0]   fid;
		logic [TIME_W:0]   next;
		sent = 0;
		seg_left = 0;
		start_pct = 50;
		while (sent < count) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 3))
					0: start_pct = 25;
					1: start_pct = 50;
					2: start_pct = 75;
					default: start_pct = 97;
				endcase
				seg_left = (start_pct == 97) ? $urandom_range(60, 150) : $urandom_range(10, 80);
			end
			seg_left--;
			if ($urandom_range(0, 99) < 5) begin
				cmd = 1'($urandom_range(0, 1));
				stamp_cursor = $urandom;
			end else begin
				cmd = ($urandom_range(0, 99) < start_pct) ? CMD_START : CMD_END;
				if ($urandom_range(0, 99) < 3)
					next = {1'b0, stamp_cursor} + $urandom_range(0, 1 << 20);
				else
					next = {1'b0, stamp_cursor} + $urandom_range(0, 16);
				stamp_cursor = next[TIME_W] ? TICK_MAX : next[TIME_W-1:0];
			end
			fid = ID_W'($urandom_range(0, 255));
			push_event(cmd, fid, stamp_cursor);
			sent++;
		end
	endtask

	// Main sequence.
	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		stamp_cursor = '0;
		arst_n        <= 1'b0;
		ev_if.valid   <= 1'b0;
		ev_if.cmd     <= CMD_START;
		ev_if.func_id <= '0;
		ev_if.stamp   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();

		idle_pct = 0;
		stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		idle_pct = 62;
		stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		idle_pct = 0;
		stall_pct = 62;
		run_random_phase(PHASE_ITEMS);
		idle_pct = 32;
		stall_pct = 32;
		run_random_phase(PHASE_ITEMS);
		ev_if.valid <= 1'b0;

		// Let the last results come back, then watch for stray words.
		while (sb.pending() != 0) @(posedge clk);
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d events: %0d charged, %0d empty-stack starts,",
			sb.checked, sb.accepted, sb.status_count[ST_CHARGED], sb.status_count[ST_NONE]);
		$display("%0d full-stack drops, %0d empty-stack drops, over four idle/stall mixes.",
			sb.status_count[ST_OVERFLOW], sb.status_count[ST_UNDERFLOW]);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches.", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
